### src/double_sha256_header_hasher_defines.svh
// ----------------------------------------------------------------------------
// double_sha256_header_hasher_defines.svh
// Assertion macros shared by the double SHA-256 header hasher RTL.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_SHA256_HEADER_HASHER_DEFINES_SVH
`define DOUBLE_SHA256_HEADER_HASHER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define DSHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define DSHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dsha_pkg.sv
// ----------------------------------------------------------------------------
// dsha_pkg
// Types, SHA-256 constants and sequencer codes for the header hasher.
// ----------------------------------------------------------------------------
package dsha_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [7:0][31:0]  hstate_t;   // index 0 is variable a / H0
  typedef logic [15:0][31:0] window_t;   // index 0 is the oldest word

  // Schedule taps that feed the shared round unit
  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w9;
    word_t w14;
  } sched_taps_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    BLK_FIRST,
    BLK_SECOND,
    BLK_DIGEST
  } blk_t;

  localparam logic [4:0] BLK1_LAST_WORD = 5'd15;
  localparam logic [4:0] HDR_LAST_WORD  = 5'd19;
  localparam logic [5:0] RND_LAST       = 6'd63;

  localparam word_t PAD_WORD   = 32'h8000_0000;
  localparam word_t LEN_HEADER = 32'h0000_0280;  // 640 bits
  localparam word_t LEN_DIGEST = 32'h0000_0100;  // 256 bits

  // Initial hash value, H7 down to H0
  localparam hstate_t IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

### src/dsha_if.sv
// ----------------------------------------------------------------------------
// dsha_if
// Valid/ready channels for header words in and digest results out.
// ----------------------------------------------------------------------------
interface dsha_in_if;
  logic                valid;
  logic                ready;
  dsha_pkg::word_t     header_word;

  modport source (output valid, output header_word, input ready);
  modport sink   (input valid, input header_word, output ready);
endinterface

interface dsha_out_if;
  logic                valid;
  logic                ready;
  dsha_pkg::word_t     digest_word0;
  dsha_pkg::word_t     digest_word1;
  dsha_pkg::word_t     digest_word2;
  dsha_pkg::word_t     digest_word3;
  dsha_pkg::word_t     digest_word4;
  dsha_pkg::word_t     digest_word5;
  dsha_pkg::word_t     digest_word6;
  dsha_pkg::word_t     digest_word7;
  logic                meets_target;

  modport source (
    output valid, input ready,
    output digest_word0, output digest_word1, output digest_word2, output digest_word3,
    output digest_word4, output digest_word5, output digest_word6, output digest_word7,
    output meets_target
  );
  modport sink (
    input valid, output ready,
    input digest_word0, input digest_word1, input digest_word2, input digest_word3,
    input digest_word4, input digest_word5, input digest_word6, input digest_word7,
    input meets_target
  );
endinterface

### src/dsha_round.sv
// ----------------------------------------------------------------------------
// dsha_round
// One SHA-256 round plus one message schedule expansion step.
// ----------------------------------------------------------------------------
module dsha_round (
  input  dsha_pkg::hstate_t     wv,
  input  dsha_pkg::word_t       k_word,
  input  dsha_pkg::sched_taps_t taps,
  output dsha_pkg::hstate_t     wv_nxt,
  output dsha_pkg::word_t       w_new
);

  function automatic dsha_pkg::word_t bsig0(dsha_pkg::word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic dsha_pkg::word_t bsig1(dsha_pkg::word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic dsha_pkg::word_t ssig0(dsha_pkg::word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic dsha_pkg::word_t ssig1(dsha_pkg::word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  dsha_pkg::word_t t1;
  dsha_pkg::word_t t2;
  dsha_pkg::word_t ch;
  dsha_pkg::word_t maj;

  // round function on a..h
  assign ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
  assign maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  assign t1  = wv[7] + bsig1(wv[4]) + ch + k_word + taps.w0;
  assign t2  = bsig0(wv[0]) + maj;

  assign wv_nxt = {wv[6], wv[5], wv[4], wv[3] + t1, wv[2], wv[1], wv[0], t1 + t2};

  // next schedule word, sixteen rounds ahead
  assign w_new = ssig1(taps.w14) + taps.w9 + ssig0(taps.w1) + taps.w0;

endmodule

### src/double_sha256_header_hasher.sv
// ----------------------------------------------------------------------------
// double_sha256_header_hasher
// Double SHA-256 of an 80-byte block header fed as twenty big-endian words.
// ----------------------------------------------------------------------------
// Words are taken one per cycle while the block is loading. After the
// sixteenth word the block compresses the first message block (64 rounds
// and a finalize step, not ready throughout). After the twentieth word it
// compresses the padded second block and then the padded 32-byte digest,
// then loads the result register, waiting in the emit state while that
// register still holds an untaken digest, before the next header word is
// taken. The rate is bounded by the single round unit that runs one SHA-256
// round per cycle. The result register holds a digest until it is taken;
// header words keep loading meanwhile.
`include "double_sha256_header_hasher_defines.svh"

module double_sha256_header_hasher (
  input  logic        clk,
  input  logic        rst_n,
  dsha_in_if.sink     in_ch,
  dsha_out_if.source  out_ch
);

  dsha_pkg::state_t    state_r, state_nxt;
  dsha_pkg::blk_t      blk_r, blk_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic [5:0]          rnd_r, rnd_nxt;
  dsha_pkg::hstate_t   cv_r, cv_nxt;
  dsha_pkg::hstate_t   wv_r, wv_nxt;
  dsha_pkg::window_t   win_r, win_nxt;
  logic                out_valid_r, out_valid_nxt;
  dsha_pkg::hstate_t   out_dig_r, out_dig_nxt;
  logic                out_tgt_r, out_tgt_nxt;

  dsha_pkg::hstate_t   cv_sum;
  dsha_pkg::hstate_t   wv_round;
  dsha_pkg::word_t     w_new;
  dsha_pkg::sched_taps_t taps;
  logic                in_accept;

  // shared round unit
  assign taps = '{w0: win_r[0], w1: win_r[1], w9: win_r[9], w14: win_r[14]};

  dsha_round u_round (
    .wv     (wv_r),
    .k_word (dsha_pkg::K_TABLE[rnd_r]),
    .taps   (taps),
    .wv_nxt (wv_round),
    .w_new  (w_new)
  );

  // chaining value update at the end of a compression
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      cv_sum[j] = cv_r[j] + wv_r[j];
    end
  end

  assign in_ch.ready = (state_r == dsha_pkg::ST_LOAD);
  assign in_accept   = in_ch.valid & in_ch.ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    blk_nxt       = blk_r;
    cnt_nxt       = cnt_r;
    rnd_nxt       = rnd_r;
    cv_nxt        = cv_r;
    wv_nxt        = wv_r;
    win_nxt       = win_r;
    out_dig_nxt   = out_dig_r;
    out_tgt_nxt   = out_tgt_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;

    unique case (state_r)
      dsha_pkg::ST_LOAD: begin
        if (in_accept) begin
          win_nxt[cnt_r[3:0]] = in_ch.header_word;
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_r == dsha_pkg::BLK1_LAST_WORD) begin
            cv_nxt    = dsha_pkg::IV;
            wv_nxt    = dsha_pkg::IV;
            blk_nxt   = dsha_pkg::BLK_FIRST;
            state_nxt = dsha_pkg::ST_ROUND;
          end else if (cnt_r == dsha_pkg::HDR_LAST_WORD) begin
            cnt_nxt   = 5'd0;
            wv_nxt    = cv_r;
            blk_nxt   = dsha_pkg::BLK_SECOND;
            state_nxt = dsha_pkg::ST_ROUND;
          end
        end
      end

      dsha_pkg::ST_ROUND: begin
        wv_nxt  = wv_round;
        win_nxt = {w_new, win_r[15:1]};
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == dsha_pkg::RND_LAST) begin
          state_nxt = dsha_pkg::ST_FIN;
        end
      end

      dsha_pkg::ST_FIN: begin
        unique case (blk_r)
          // header tail goes into entries 0..3; padding and length preset
          dsha_pkg::BLK_FIRST: begin
            cv_nxt     = cv_sum;
            win_nxt[4] = dsha_pkg::PAD_WORD;
            for (int j = 5; j < 15; j++) begin
              win_nxt[j] = '0;
            end
            win_nxt[15] = dsha_pkg::LEN_HEADER;
            state_nxt   = dsha_pkg::ST_LOAD;
          end
          // first digest becomes the message of the outer hash
          dsha_pkg::BLK_SECOND: begin
            win_nxt[7:0] = cv_sum;
            win_nxt[8]   = dsha_pkg::PAD_WORD;
            for (int j = 9; j < 15; j++) begin
              win_nxt[j] = '0;
            end
            win_nxt[15] = dsha_pkg::LEN_DIGEST;
            cv_nxt      = dsha_pkg::IV;
            wv_nxt      = dsha_pkg::IV;
            blk_nxt     = dsha_pkg::BLK_DIGEST;
            state_nxt   = dsha_pkg::ST_ROUND;
          end
          dsha_pkg::BLK_DIGEST: begin
            cv_nxt    = cv_sum;
            state_nxt = dsha_pkg::ST_EMIT;
          end
          default: begin
            state_nxt = dsha_pkg::ST_LOAD;
          end
        endcase
      end

      dsha_pkg::ST_EMIT: begin
        // wait for room in the result register
        if (!out_valid_r || out_ch.ready) begin
          out_dig_nxt   = cv_r;
          out_tgt_nxt   = (cv_r[0][31:16] == 16'd0);
          out_valid_nxt = 1'b1;
          state_nxt     = dsha_pkg::ST_LOAD;
        end
      end

      default: begin
        state_nxt = dsha_pkg::ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsha_pkg::ST_LOAD;
      blk_r       <= dsha_pkg::BLK_FIRST;
      cnt_r       <= 5'd0;
      rnd_r       <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      blk_r       <= blk_nxt;
      cnt_r       <= cnt_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cv_r      <= cv_nxt;
    wv_r      <= wv_nxt;
    win_r     <= win_nxt;
    out_dig_r <= out_dig_nxt;
    out_tgt_r <= out_tgt_nxt;
  end

  // result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.digest_word0 = out_dig_r[0];
  assign out_ch.digest_word1 = out_dig_r[1];
  assign out_ch.digest_word2 = out_dig_r[2];
  assign out_ch.digest_word3 = out_dig_r[3];
  assign out_ch.digest_word4 = out_dig_r[4];
  assign out_ch.digest_word5 = out_dig_r[5];
  assign out_ch.digest_word6 = out_dig_r[6];
  assign out_ch.digest_word7 = out_dig_r[7];
  assign out_ch.meets_target = out_tgt_r;

  // checks
  `DSHA_ASSERT_NEXT(a_busy_after_block, in_accept && (cnt_r == dsha_pkg::BLK1_LAST_WORD), !in_ch.ready, "block 1 did not start")
  `DSHA_ASSERT_NOW(a_round_ctx, state_r == dsha_pkg::ST_ROUND, ((cnt_r == 5'd16) && (blk_r == dsha_pkg::BLK_FIRST)) || ((cnt_r == 5'd0) && (blk_r != dsha_pkg::BLK_FIRST)), "word count and block disagree")
  `DSHA_ASSERT_NOW(a_rnd_idle, state_r != dsha_pkg::ST_ROUND, rnd_r == 6'd0, "round counter not at zero")
  `DSHA_ASSERT_NOW(a_emit_src, $rose(out_valid_r), $past(state_r == dsha_pkg::ST_EMIT), "result without emit")

endmodule
